/* rtl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache tag model.
// No dependencies; salc_way_sel, salc_stats and the top level import this package.
`default_nettype none

package salc_pkg;

   localparam int SET_COUNT_DEF    = 16;
   localparam int WAY_COUNT_DEF    = 2;
   localparam int OFFSET_BITS_DEF  = 5;
   localparam int ADDRESS_BITS_DEF = 20;

   localparam int LAT_W   = 10;
   localparam int BYTES_W = 4;
   localparam int COST_W  = 12;
   localparam int HITS_W  = 32;
   localparam int CYC_W   = 40;
   localparam int CSR_W   = 2;

   localparam logic [LAT_W-1:0] HIT_LAT_RST  = 10'd7;
   localparam logic [LAT_W-1:0] MISS_LAT_RST = 10'd122;
   localparam logic [LAT_W-1:0] WB_PEN_RST   = 10'd101;

   localparam logic [CSR_W-1:0] CSR_HIT_LAT  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MISS_LAT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_WB_PEN   = 2'd2;

   // Row layout: LRU bit, then valid/dirty per way, then the two tags
   localparam int ROW_OLDER  = 0;
   localparam int ROW_VALID0 = 1;
   localparam int ROW_DIRTY0 = 2;
   localparam int ROW_VALID1 = 3;
   localparam int ROW_DIRTY1 = 4;
   localparam int ROW_FLAGS  = 5;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_ACCUM
   } state_type;

   typedef struct packed {
      logic hit;
      logic wrote_back;
      logic way;
   } lookup_type;

endpackage

`default_nettype wire

/* rtl/salc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the per-set row store.
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/salc_way_sel.sv */
// Tag compare, victim choice and row update for one two-way set.
// Depends on salc_pkg for the row layout and the lookup result struct.
`default_nettype none

module salc_way_sel import salc_pkg::*; #(
   parameter int TAG_W = 11
) (
   input  wire logic [2*TAG_W+ROW_FLAGS-1:0] row,
   input  wire logic [TAG_W-1:0]             tag,
   input  wire logic                         is_write,
   output lookup_type                        result,
   output logic      [2*TAG_W+ROW_FLAGS-1:0] new_row
);

   logic             valid0, valid1, dirty0, dirty1;
   logic             match0, match1, hit, way, victim;
   logic [TAG_W-1:0] tag0, tag1;

   always_comb begin
      valid0 = row[ROW_VALID0];
      valid1 = row[ROW_VALID1];
      dirty0 = row[ROW_DIRTY0];
      dirty1 = row[ROW_DIRTY1];
      tag0   = row[ROW_FLAGS +: TAG_W];
      tag1   = row[ROW_FLAGS+TAG_W +: TAG_W];
      match0 = valid0 && (tag0 == tag);
      match1 = valid1 && (tag1 == tag);
      hit    = match0 || match1;
      if (!valid1) begin
         victim = 1'b1;
      end else if (!valid0) begin
         victim = 1'b0;
      end else begin
         victim = row[ROW_OLDER];
      end
      way = hit ? !match0 : victim;

      result.hit        = hit;
      result.way        = way;
      result.wrote_back = !hit && (way ? (valid1 && dirty1) : (valid0 && dirty0));

      new_row            = row;
      new_row[ROW_OLDER] = !way;
      if (way) begin
         new_row[ROW_VALID1]                 = 1'b1;
         new_row[ROW_DIRTY1]                 = hit ? (dirty1 || is_write) : is_write;
         new_row[ROW_FLAGS+TAG_W +: TAG_W]   = tag;
      end else begin
         new_row[ROW_VALID0]                 = 1'b1;
         new_row[ROW_DIRTY0]                 = hit ? (dirty0 || is_write) : is_write;
         new_row[ROW_FLAGS +: TAG_W]         = tag;
      end
   end

endmodule

`default_nettype wire

/* rtl/salc_stats.sv */
// Saturating hit, miss and cycle totals.
// Depends on salc_pkg for counter widths.
`default_nettype none

module salc_stats import salc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              update,
   input  wire logic              hit,
   input  wire logic [COST_W-1:0] cost,
   output logic      [HITS_W-1:0] hit_total,
   output logic      [HITS_W-1:0] miss_total,
   output logic      [CYC_W-1:0]  cycle_total
);

   logic [HITS_W-1:0] hit_ff, hit_in, miss_ff, miss_in;
   logic [CYC_W-1:0]  cyc_ff, cyc_in;
   logic [CYC_W:0]    cyc_sum;

   always_comb begin
      hit_in  = hit_ff;
      miss_in = miss_ff;
      cyc_in  = cyc_ff;
      cyc_sum = {1'b0, cyc_ff} + {{(CYC_W+1-COST_W){1'b0}}, cost};
      if (update) begin
         if (hit && !(&hit_ff)) begin
            hit_in = hit_ff + 1'b1;
         end
         if (!hit && !(&miss_ff)) begin
            miss_in = miss_ff + 1'b1;
         end
         cyc_in = cyc_sum[CYC_W] ? {CYC_W{1'b1}} : cyc_sum[CYC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= '0;
         miss_ff <= '0;
         cyc_ff  <= '0;
      end else begin
         hit_ff  <= hit_in;
         miss_ff <= miss_in;
         cyc_ff  <= cyc_in;
      end
   end

   assign hit_total   = hit_ff;
   assign miss_total  = miss_ff;
   assign cycle_total = cyc_ff;

endmodule

`default_nettype wire

/* rtl/set_assoc_lru_cache_tag_model.sv */
// Top level of the two-way set-associative LRU write-back cache tag model.
// Depends on salc_pkg, salc_ram, salc_way_sel and salc_stats.
//
//   channel   handshake               payload
//   request   start / busy            req_address, req_byte_count, req_is_write
//   response  rsp_valid (strobe)      rsp_hit, rsp_wrote_back, rsp_access_cycles,
//                                     rsp_hits_so_far, rsp_misses_so_far,
//                                     rsp_cycles_so_far
//   csr       csr_valid / csr_ready   csr_index, csr_wdata
//
// An access steps through set row read, lookup with row write-back, and total update.
// The result strobes in the cycle after the total update; a new start is taken in the same cycle.
// The row memory's one read port and the read-modify-write of a row set this sequence.
// After reset, busy stays high while every row of the row memory is cleared.
// The receiver cannot stall; the csr channel is always ready.
`default_nettype none

module set_assoc_lru_cache_tag_model import salc_pkg::*; #(
   parameter int SET_COUNT    = SET_COUNT_DEF,
   parameter int WAY_COUNT    = WAY_COUNT_DEF,
   parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [ADDRESS_BITS-1:0] req_address,
   input  wire logic [BYTES_W-1:0]      req_byte_count,
   input  wire logic                    req_is_write,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic                         rsp_wrote_back,
   output logic      [COST_W-1:0]       rsp_access_cycles,
   output logic      [HITS_W-1:0]       rsp_hits_so_far,
   output logic      [HITS_W-1:0]       rsp_misses_so_far,
   output logic      [CYC_W-1:0]        rsp_cycles_so_far,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_W-1:0]        csr_index,
   input  wire logic [LAT_W-1:0]        csr_wdata
);

   localparam int SET_W = $clog2(SET_COUNT);
   localparam int TAG_W = ADDRESS_BITS - OFFSET_BITS - SET_W;
   localparam int ROW_W = WAY_COUNT * TAG_W + ROW_FLAGS;
   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

   state_type         state_ff, state_in;
   logic [SET_W-1:0]  clr_ff, clr_in;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic              wr_ff;
   logic              hit_ff, wb_ff, rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [LAT_W-1:0]  hit_lat_ff, miss_lat_ff, wb_pen_ff;

   logic              accept, mem_wr_en, stats_update;
   logic [SET_W-1:0]  mem_wr_addr;
   logic [ROW_W-1:0]  mem_wr_data, rd_row, new_row;
   lookup_type        lookup;
   logic [BYTES_W-1:0] half_bytes;
   logic [BYTES_W:0]  bytes_inc;

   assign accept = start && !busy;

   salc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(SET_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_address[OFFSET_BITS +: SET_W]),
      .rd_data (rd_row)
   );

   salc_way_sel #(
      .TAG_W(TAG_W)
   ) u_way_sel (
      .row      (rd_row),
      .tag      (tag_ff),
      .is_write (wr_ff),
      .result   (lookup),
      .new_row  (new_row)
   );

   salc_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .update      (stats_update),
      .hit         (hit_ff),
      .cost        (cost_ff),
      .hit_total   (rsp_hits_so_far),
      .miss_total  (rsp_misses_so_far),
      .cycle_total (rsp_cycles_so_far)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy         = 1'b1;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = set_ff;
      mem_wr_data  = new_row;
      stats_update = 1'b0;
      rsp_valid_in = 1'b0;
      clr_in       = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_LOOKUP: begin
            mem_wr_en = 1'b1;
         end
         ST_ACCUM: begin
            stats_update = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      bytes_inc  = {1'b0, bytes_ff} + 1'b1;
      half_bytes = bytes_inc[BYTES_W:1];
      cost_in    = COST_W'(lookup.hit ? hit_lat_ff : miss_lat_ff)
                 + COST_W'(half_bytes)
                 + (lookup.wrote_back ? COST_W'(wb_pen_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_lat_ff   <= HIT_LAT_RST;
         miss_lat_ff  <= MISS_LAT_RST;
         wb_pen_ff    <= WB_PEN_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_HIT_LAT:  hit_lat_ff  <= csr_wdata;
               CSR_MISS_LAT: miss_lat_ff <= csr_wdata;
               CSR_WB_PEN:   wb_pen_ff   <= csr_wdata;
               default:      hit_lat_ff  <= hit_lat_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff   <= req_address[OFFSET_BITS +: SET_W];
         tag_ff   <= req_address[ADDRESS_BITS-1 -: TAG_W];
         bytes_ff <= req_byte_count;
         wr_ff    <= req_is_write;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_ff  <= lookup.hit;
         wb_ff   <= lookup.wrote_back;
         cost_ff <= cost_in;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_wrote_back    = wb_ff;
   assign rsp_access_cycles = cost_ff;

endmodule

`default_nettype wire
